>>> design/wmsc_pkg.sv
package wmsc_pkg;

    // Default sizes, handed to the top level's parameters.
    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    // Angles in Q3.12 radians.
    localparam int PI_Q        = 12868;
    localparam int TWO_PI_Q    = 25736;
    localparam int TWO_PI_BITS = 15;

    localparam int WINDOW_RESET      = 8;
    localparam int WINDOW_FIELD_BITS = 7;
    localparam int THRESH_BITS       = 15;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 15;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEADY_THRESHOLD = 2'd1;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> design/wmsc_div.sv
module wmsc_div
    import wmsc_pkg::*;
#(
    parameter int NUM_BITS = 24,
    parameter int DEN_BITS = 15
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_dividend,
    input  logic [DEN_BITS-1:0] i_divisor,
    output t_div_stat           o_stat,
    output logic [NUM_BITS-1:0] o_quotient,
    output logic [DEN_BITS-1:0] o_remainder
);

    localparam int STEPS    = NUM_BITS / 2;
    localparam int CNT_BITS = $clog2(STEPS + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [NUM_BITS-1:0] r_quo;
    logic [DEN_BITS-1:0] r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [NUM_BITS-1:0] n_quo;
    logic [DEN_BITS-1:0] n_rem;

    // Two restoring steps per cycle: the dividend shifts out of the top of
    // the register while quotient bits enter at the bottom.
    always_comb begin
        logic [DEN_BITS:0] trial;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            trial = {n_rem, n_quo[NUM_BITS-1]};
            n_quo = {n_quo[NUM_BITS-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                trial    = trial - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[DEN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_BITS'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

>>> design/windowed_mean_steadiness_check.sv
// Channel     | Direction | Handshake                | Payload
// sample in   | in        | i_in_valid / o_in_stall  | i_sample
// result out  | out       | o_out_valid / i_out_stall| o_ready_res, o_mean_value, o_steady
// config      | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// A request with a full window runs read, update, mean division, deviation, 2*pi division
// and finish, and no new request is taken until it leaves finish; the shared divider retires
// two quotient bits a cycle and runs twice, once for the mean and once to fold the deviation
// by 2*pi. A request that only fills the window goes from update straight to finish.
// Reset is synchronous and active low; the sample ring needs no clearing pass.
// A stalled result waits in the output register while the next request is taken in.
module windowed_mean_steadiness_check
    import wmsc_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]    i_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_ready_res,
    output logic signed [SAMPLE_BITS-1:0]    o_mean_value,
    output logic                             o_steady,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]        i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]         i_cfg_data
);

    localparam int WIN_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int SLOT_BITS = $clog2(MAX_WINDOW);
    localparam int TOT_BITS  = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
    localparam int DEV_BITS  = SAMPLE_BITS + 1;
    localparam int DIV_BITS  = TOT_BITS + (TOT_BITS % 2);
    localparam int DEN_BITS  = (WIN_BITS > TWO_PI_BITS) ? WIN_BITS : TWO_PI_BITS;
    localparam int SUM_BITS  = DEN_BITS + 1;
    localparam int WIN_RESET = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_READ      = 9'b000000010,
        S_UPDATE    = 9'b000000100,
        S_MEAN_GO   = 9'b000001000,
        S_MEAN_WAIT = 9'b000010000,
        S_DEV       = 9'b000100000,
        S_WRAP_GO   = 9'b001000000,
        S_WRAP_WAIT = 9'b010000000,
        S_FINISH    = 9'b100000000
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [WIN_BITS-1:0]    r_window;
    logic [THRESH_BITS-1:0] r_threshold;
    logic [TOT_BITS-1:0]    r_total;
    logic [TOT_BITS-1:0]    n_total;
    logic [WIN_BITS-1:0]    r_fill;
    logic [SLOT_BITS-1:0]   r_slot;
    logic [SLOT_BITS-1:0]   n_slot;
    logic [SAMPLE_BITS-1:0] r_held_mean;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_full;
    logic [SLOT_BITS-1:0]   r_rd_addr;
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic [DEV_BITS-1:0]    r_dev;
    logic                   r_steady;
    logic [SAMPLE_BITS-1:0] r_ring [MAX_WINDOW];

    logic                   in_acc;
    logic                   out_load;
    logic                   cfg_we;
    logic [WINDOW_FIELD_BITS-1:0] cfg_win;
    logic [WIN_BITS-1:0]    win_clamped;
    logic [WIN_BITS:0]      slot_ext;
    logic [WIN_BITS:0]      win_ext;
    logic [SLOT_BITS-1:0]   oldest;
    logic [TOT_BITS-1:0]    evict_ext;
    logic [TOT_BITS-1:0]    sample_ext;
    logic [TOT_BITS-1:0]    tot_mag;
    logic [DEV_BITS-1:0]    dev_mag;
    logic [SAMPLE_BITS-1:0] q_low;
    logic [SAMPLE_BITS-1:0] mean_next;
    logic                   wrap_over;
    logic [SUM_BITS-1:0]    wrap_sum;
    logic                   steady_next;

    logic                   div_start;
    logic [DIV_BITS-1:0]    div_dividend;
    logic [DEN_BITS-1:0]    div_divisor;
    t_div_stat              div_stat;
    logic [DIV_BITS-1:0]    div_quo;
    logic [DEN_BITS-1:0]    div_rem;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign out_load    = (r_state == S_FINISH) && (!o_out_valid || !i_out_stall);

    // A window of zero behaves as one; anything above the ring depth is clipped.
    assign cfg_win = i_cfg_data[WINDOW_FIELD_BITS-1:0];
    always_comb begin
        priority if (cfg_win == '0) begin
            win_clamped = WIN_BITS'(1);
        end else if (int'(cfg_win) > MAX_WINDOW) begin
            win_clamped = WIN_BITS'(MAX_WINDOW);
        end else begin
            win_clamped = WIN_BITS'(cfg_win);
        end
    end

    // The oldest sample sits window slots behind the write slot, modulo the ring depth.
    assign slot_ext = (WIN_BITS + 1)'(r_slot);
    assign win_ext  = (WIN_BITS + 1)'(r_window);
    always_comb begin
        if (slot_ext >= win_ext) begin
            oldest = SLOT_BITS'(slot_ext - win_ext);
        end else begin
            oldest = SLOT_BITS'(slot_ext + (WIN_BITS + 1)'(MAX_WINDOW) - win_ext);
        end
    end

    assign evict_ext  = r_full ? {{(TOT_BITS - SAMPLE_BITS){r_rd_data[SAMPLE_BITS-1]}},
                                  r_rd_data} : '0;
    assign sample_ext = {{(TOT_BITS - SAMPLE_BITS){r_sample[SAMPLE_BITS-1]}}, r_sample};
    assign n_total    = r_total - evict_ext + sample_ext;
    assign n_slot     = (r_slot == SLOT_BITS'(MAX_WINDOW - 1)) ? '0 : r_slot + SLOT_BITS'(1);

    assign tot_mag = r_total[TOT_BITS-1] ? (~r_total + TOT_BITS'(1)) : r_total;
    assign dev_mag = r_dev[DEV_BITS-1] ? (~r_dev + DEV_BITS'(1)) : r_dev;

    // The mean is truncated toward zero, so the sign is put back on the magnitude.
    assign q_low     = div_quo[SAMPLE_BITS-1:0];
    assign mean_next = r_total[TOT_BITS-1] ? (~q_low + SAMPLE_BITS'(1)) : q_low;

    // Above pi the folded deviation is 2*pi - r, which is within the threshold
    // exactly when r + threshold reaches 2*pi.
    assign wrap_over   = div_rem > DEN_BITS'(PI_Q);
    assign wrap_sum    = SUM_BITS'(div_rem) + SUM_BITS'(r_threshold);
    assign steady_next = wrap_over ? (wrap_sum >= SUM_BITS'(TWO_PI_Q))
                                   : (SUM_BITS'(div_rem) <= SUM_BITS'(r_threshold));

    assign div_start    = (r_state == S_MEAN_GO) || (r_state == S_WRAP_GO);
    assign div_dividend = (r_state == S_MEAN_GO) ? DIV_BITS'(tot_mag) : DIV_BITS'(dev_mag);
    assign div_divisor  = (r_state == S_MEAN_GO) ? DEN_BITS'(r_window)
                                                 : DEN_BITS'(TWO_PI_Q);

    wmsc_div #(
        .NUM_BITS (DIV_BITS),
        .DEN_BITS (DEN_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_stat      (div_stat),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_READ;
            end
            S_READ:      n_state = S_UPDATE;
            S_UPDATE:    n_state = r_full ? S_MEAN_GO : S_FINISH;
            S_MEAN_GO:   n_state = S_MEAN_WAIT;
            S_MEAN_WAIT: begin
                if (div_stat.done) n_state = S_DEV;
            end
            S_DEV:       n_state = S_WRAP_GO;
            S_WRAP_GO:   n_state = S_WRAP_WAIT;
            S_WRAP_WAIT: begin
                if (div_stat.done) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_load) n_state = S_IDLE;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= WIN_BITS'(WIN_RESET);
            r_threshold <= '0;
            r_total     <= '0;
            r_fill      <= '0;
            r_slot      <= '0;
            r_held_mean <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Changing the window length empties it; the ring is refilled from slot 0.
            if (cfg_we && (i_cfg_index == REG_WINDOW_LENGTH)) begin
                r_window <= win_clamped;
                r_total  <= '0;
                r_fill   <= '0;
                r_slot   <= '0;
            end else if (r_state == S_UPDATE) begin
                r_total <= n_total;
                r_slot  <= n_slot;
                if (!r_full) r_fill <= r_fill + WIN_BITS'(1);
            end
            if (cfg_we && (i_cfg_index == REG_STEADY_THRESHOLD)) begin
                r_threshold <= i_cfg_data[THRESH_BITS-1:0];
            end
            if ((r_state == S_MEAN_WAIT) && div_stat.done) begin
                r_held_mean <= mean_next;
            end
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample  <= i_sample;
            r_full    <= (r_fill >= r_window);
            r_rd_addr <= oldest;
        end
        if (r_state == S_DEV) begin
            r_dev <= {r_held_mean[SAMPLE_BITS-1], r_held_mean}
                   - {r_sample[SAMPLE_BITS-1], r_sample};
        end
        if ((r_state == S_WRAP_WAIT) && div_stat.done) begin
            r_steady <= steady_next;
        end
        if (out_load) begin
            o_ready_res  <= r_full;
            o_mean_value <= r_held_mean;
            o_steady     <= r_full && r_steady;
        end
    end

    // The evicted sample is read in the cycle before the new one is written.
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPDATE) begin
            r_ring[r_slot] <= r_sample;
        end
        r_rd_data <= r_ring[r_rd_addr];
    end

endmodule

>>> design/wmsc_chk.sv
module wmsc_chk
    import wmsc_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic signed [SAMPLE_BITS-1:0] i_sample,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_ready_res,
    input logic signed [SAMPLE_BITS-1:0] o_mean_value,
    input logic                          o_steady,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [CFG_INDEX_BITS-1:0]     i_cfg_index,
    input logic [CFG_DATA_BITS-1:0]      i_cfg_data
);

    // A result held back by the receiver keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_mean_value)
            && $stable(o_ready_res) && $stable(o_steady))
        else $error("result changed while stalled");

    // A result from a window that is still filling never reports steady.
    a_steady_needs_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ready_res |-> !o_steady)
        else $error("steady flagged without a full window");

    // One request at a time: the input stalls right after a request is taken.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while busy");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind windowed_mean_steadiness_check wmsc_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_wmsc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_sample     (i_sample),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_ready_res  (o_ready_res),
    .o_mean_value (o_mean_value),
    .o_steady     (o_steady),
    .i_cfg_valid  (i_cfg_valid),
    .o_cfg_ready  (o_cfg_ready),
    .i_cfg_index  (i_cfg_index),
    .i_cfg_data   (i_cfg_data)
);
